// ----- src/tws_pkg.sv -----
// shared constants, types and command structs for the temperature window statistics block
package tws_pkg;

  // field widths
  localparam int ADC_W  = 10;
  localparam int TEMP_W = 19;
  localparam int EXT_W  = 20;

  // default window length
  localparam int WINDOW_LEN_DEF = 16;

  // code to 1/1024 degree scale, and reset values of the extremes
  localparam logic [TEMP_W-1:0] TEMP_SCALE = TEMP_W'(500);
  localparam logic signed [EXT_W-1:0] MIN_RESET = EXT_W'(512000);
  localparam logic signed [EXT_W-1:0] MAX_RESET = -EXT_W'(51200);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  // commands from sequencer to datapath
  typedef struct packed {
    logic load;
    logic update;
    logic div_step;
    logic publish;
  } cmd_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ----- src/tws_ctrl.sv -----
// sequencer for the temperature window statistics block
module tws_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tws_pkg::sts_t sts,
  output tws_pkg::cmd_t cmd
);
  import tws_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (cmd.load) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_DIV;
      S_DIV:    if (sts.div_done) state_nxt = S_DONE;
      S_DONE:   if (cmd.publish) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd.load     = in_valid && (state_r == S_IDLE);
    cmd.update   = (state_r == S_UPDATE);
    cmd.div_step = (state_r == S_DIV);
    cmd.publish  = (state_r == S_DONE) && (!out_valid_r || out_ready);
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.update, cmd.div_step, cmd.publish}))
    else $error("more than one datapath command at once");

  // an accepted request always goes to the window update next
  a_load_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_UPDATE))
    else $error("accepted request not followed by update");

  // last divide step leads to the result stage
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_done) |=> (state_r == S_DONE))
    else $error("divider finished but result not staged");

  // publishing always leaves a valid result
  a_publish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid)
    else $error("published result not valid");

endmodule

// ----- src/tws_dp.sv -----
// datapath: scaling, window ring, running sum, extremes and restoring divider
module tws_dp #(
  parameter int WINDOW_LEN = tws_pkg::WINDOW_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tws_pkg::cmd_t                     cmd,
  output tws_pkg::sts_t                     sts,
  input  logic        [tws_pkg::ADC_W-1:0]  in_adc_code,
  output logic        [tws_pkg::TEMP_W-1:0] out_temp_now,
  output logic signed [tws_pkg::EXT_W-1:0]  out_temp_min,
  output logic signed [tws_pkg::EXT_W-1:0]  out_temp_max,
  output logic        [tws_pkg::TEMP_W-1:0] out_temp_mean
);
  import tws_pkg::*;

  localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W     = TEMP_W + CNT_W;
  localparam int STEP_W    = $clog2(SUM_W);

  // window ring memory
  logic [TEMP_W-1:0] ring_mem [WINDOW_LEN];

  logic        [TEMP_W-1:0] temp_r;
  logic        [TEMP_W-1:0] rd_r;
  logic        [SLOT_W-1:0] slot_r, slot_nxt;
  logic        [CNT_W-1:0]  held_r, held_nxt;
  logic        [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [EXT_W-1:0]  lowest_r, lowest_nxt;
  logic signed [EXT_W-1:0]  highest_r, highest_nxt;
  logic signed [EXT_W-1:0]  temp_ext;
  logic                     full;

  // divider state
  logic [SUM_W-1:0]  dq_r, dq_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    rem_sh;
  logic [STEP_W-1:0] step_r, step_nxt;

  // output registers
  logic        [TEMP_W-1:0] now_out_r;
  logic        [TEMP_W-1:0] mean_out_r;
  logic signed [EXT_W-1:0]  min_out_r;
  logic signed [EXT_W-1:0]  max_out_r;

  // window bookkeeping for the update step
  always_comb begin
    full     = (held_r == CNT_W'(WINDOW_LEN));
    temp_ext = $signed({1'b0, temp_r});
    sum_nxt  = sum_r + SUM_W'(temp_r) - (full ? SUM_W'(rd_r) : SUM_W'(0));
    slot_nxt = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
    held_nxt = full ? held_r : held_r + CNT_W'(1);
    lowest_nxt  = (temp_ext < lowest_r)  ? temp_ext : lowest_r;
    highest_nxt = (temp_ext > highest_r) ? temp_ext : highest_r;
  end

  // one restoring divide step: running sum over held count
  always_comb begin
    rem_sh = {rem_r, dq_r[SUM_W-1]};
    if (rem_sh >= {1'b0, held_r}) begin
      rem_nxt = CNT_W'(rem_sh - {1'b0, held_r});
      dq_nxt  = {dq_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[CNT_W-1:0];
      dq_nxt  = {dq_r[SUM_W-2:0], 1'b0};
    end
    step_nxt     = step_r + STEP_W'(1);
    sts.div_done = (step_r == STEP_W'(SUM_W - 1));
  end

  // ring memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring_mem[slot_r] <= temp_r;
    end
    if (cmd.load) begin
      rd_r <= ring_mem[slot_r];
    end
  end

  // window control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      held_r    <= '0;
      sum_r     <= '0;
      lowest_r  <= MIN_RESET;
      highest_r <= MAX_RESET;
    end else if (cmd.update) begin
      slot_r    <= slot_nxt;
      held_r    <= held_nxt;
      sum_r     <= sum_nxt;
      lowest_r  <= lowest_nxt;
      highest_r <= highest_nxt;
    end
  end

  // scaling, divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_r <= TEMP_W'(in_adc_code) * TEMP_SCALE;
    end
    if (cmd.update) begin
      dq_r   <= sum_nxt;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      dq_r   <= dq_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_nxt;
    end
    if (cmd.publish) begin
      now_out_r  <= temp_r;
      min_out_r  <= lowest_r;
      max_out_r  <= highest_r;
      mean_out_r <= dq_r[TEMP_W-1:0];
    end
  end

  assign out_temp_now  = now_out_r;
  assign out_temp_min  = min_out_r;
  assign out_temp_max  = max_out_r;
  assign out_temp_mean = mean_out_r;

endmodule

// ----- src/temperature_window_stats.sv -----
// top level: windowed mean temperature with minimum and maximum held since reset
// a request is scaled on acceptance, the window is then updated, and the restoring divider
// forms the mean one quotient bit per cycle over SUM_W = 19 + clog2(WINDOW_LEN + 1) bits;
// a new request is taken only once the previous result has been published, which waits
// for out_ready while an earlier result is still held
// reset: synchronous active low; ring memory is not cleared, a fill count masks
// unwritten slots, so requests are taken from the first cycle after reset
module temperature_window_stats #(
  parameter int WINDOW_LEN = tws_pkg::WINDOW_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic        [tws_pkg::ADC_W-1:0]  in_adc_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [tws_pkg::TEMP_W-1:0] out_temp_now,
  output logic signed [tws_pkg::EXT_W-1:0]  out_temp_min,
  output logic signed [tws_pkg::EXT_W-1:0]  out_temp_max,
  output logic        [tws_pkg::TEMP_W-1:0] out_temp_mean
);
  import tws_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  tws_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_adc_code   (in_adc_code),
    .out_temp_now  (out_temp_now),
    .out_temp_min  (out_temp_min),
    .out_temp_max  (out_temp_max),
    .out_temp_mean (out_temp_mean)
  );

endmodule
